// ===== hw/rtl/sne_pkg.sv =====
// Shared types and constants for the sparse nearest-neighbour block expander.
`timescale 1ns / 1ps

package sne_pkg;

  localparam int COORD_W                = 16;
  localparam int VALUE_W                = 32;
  localparam int CFG_INDEX_W            = 4;
  localparam int CFG_DATA_W             = 16;
  localparam int MAX_BLOCK_SIDE_DEFAULT = 8;
  localparam int INDEX_DIV_STEPS        = 4;
  localparam int SHARE_DIV_STEPS        = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_ROWS = CFG_INDEX_W'(0),
    REG_SOURCE_COLS = CFG_INDEX_W'(1),
    REG_TARGET_ROWS = CFG_INDEX_W'(2),
    REG_TARGET_COLS = CFG_INDEX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0]        in_row;
    logic [COORD_W-1:0]        in_col;
    logic signed [VALUE_W-1:0] in_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]        out_row;
    logic [COORD_W-1:0]        out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
  } out_item_t;

endpackage

// ===== hw/rtl/sne_divpipe.sv =====
// Pipelined restoring unsigned divider with a sideband tag and enable.
`timescale 1ns / 1ps

module sne_divpipe #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 16,
  parameter int STEPS      = 4,
  parameter int TAG_W      = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [TAG_W-1:0]      in_tag,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  out_valid,
  output logic [TAG_W-1:0]      out_tag,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int STAGES = DIVIDEND_W / STEPS;
  localparam int ACC_W  = DIVISOR_W + DIVIDEND_W;

  logic [STAGES-1:0]    valid;
  logic [ACC_W-1:0]     acc [STAGES];
  logic [DIVISOR_W-1:0] dvs [STAGES];
  logic [TAG_W-1:0]     tag [STAGES];

  function automatic logic [ACC_W-1:0] div_steps(input logic [ACC_W-1:0] a_in,
                                                 input logic [DIVISOR_W-1:0] d);
    logic [ACC_W-1:0]   a;
    logic [DIVISOR_W:0] hi;
    logic               qbit;
    a = a_in;
    for (int k = 0; k < STEPS; k++) begin
      hi   = a[ACC_W-1 -: DIVISOR_W+1];
      qbit = (hi >= {1'b0, d});
      if (qbit) begin
        hi = hi - {1'b0, d};
      end
      a = {hi[DIVISOR_W-1:0], a[DIVIDEND_W-2:0], qbit};
    end
    return a;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        valid[i] <= valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= div_steps({DIVISOR_W'(0), dividend}, divisor);
      dvs[0] <= divisor;
      tag[0] <= in_tag;
      for (int i = 1; i < STAGES; i++) begin
        acc[i] <= div_steps(acc[i-1], dvs[i-1]);
        dvs[i] <= dvs[i-1];
        tag[i] <= tag[i-1];
      end
    end
  end

  assign out_valid = valid[STAGES-1];
  assign out_tag   = tag[STAGES-1];
  assign quotient  = acc[STAGES-1][DIVIDEND_W-1:0];
  assign remainder = acc[STAGES-1][ACC_W-1:DIVIDEND_W];

endmodule

// ===== hw/rtl/sparse_nearest_block_expand_top.sv =====
// Top level: maps one sparse entry to its scaled block and emits its cells.
//
//  channel | direction | handshake          | carries
//  --------+-----------+--------------------+--------------------------------
//  in      | to block  | in_valid/in_stall  | in_item: in_row, in_col, in_value
//  out     | from block| out_valid/out_stall| out_item: row, col, value, last
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  An accepted entry passes the input and product stages, eight index divider
//  stages, side and magnitude stages, four share divider stages and the tail stage
//  to reach the cell emitter, which registers its cells into out_item. The emitter
//  sends one cell a cycle while out_stall is low, holds an entry until its last
//  cell is sent and loads the next as that cell leaves; a dropped entry emits none.
//  rst is synchronous; it clears valid bits and sets every config register to 1.
//  in_stall rises when the tail stage holds an item the emitter cannot take; the
//  whole pipeline then holds and nothing is lost.
`timescale 1ns / 1ps

module sparse_nearest_block_expand_top #(
  parameter int MAX_BLOCK_SIDE = sne_pkg::MAX_BLOCK_SIDE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sne_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sne_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sne_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sne_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW     = sne_pkg::COORD_W;
  localparam int VW     = sne_pkg::VALUE_W;
  localparam int SIDE_W = $clog2(MAX_BLOCK_SIDE + 1);
  localparam int CELL_W = 2 * SIDE_W;
  localparam int PROD_W = CW + 1 + SIDE_W;

  typedef struct packed {
    logic              drop;
    logic              neg;
    logic [CW-1:0]     r0;
    logic [CW-1:0]     c0;
    logic [SIDE_W-1:0] nr;
    logic [SIDE_W-1:0] nc;
  } blk_t;

  function automatic logic [SIDE_W-1:0] block_side(input logic [CW-1:0] rem,
                                                   input logic [CW-1:0] dst,
                                                   input logic [CW-1:0] src);
    logic [CW:0]       t;
    logic [SIDE_W-1:0] n;
    t = {1'b0, rem} + {1'b0, dst};
    n = SIDE_W'(1);
    for (int k = 2; k <= MAX_BLOCK_SIDE; k++) begin
      if (PROD_W'(t) >= PROD_W'(k) * PROD_W'(src)) begin
        n = SIDE_W'(k);
      end
    end
    return n;
  endfunction

  // configuration registers
  logic [CW-1:0] source_rows;
  logic [CW-1:0] source_cols;
  logic [CW-1:0] target_rows;
  logic [CW-1:0] target_cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rows <= CW'(1);
      source_cols <= CW'(1);
      target_rows <= CW'(1);
      target_cols <= CW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (sne_pkg::cfg_reg_t'(cfg_index))
        sne_pkg::REG_SOURCE_ROWS: source_rows <= cfg_data;
        sne_pkg::REG_SOURCE_COLS: source_cols <= cfg_data;
        sne_pkg::REG_TARGET_ROWS: target_rows <= cfg_data;
        sne_pkg::REG_TARGET_COLS: target_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic em_load;

  logic s0_valid, s1_valid, s3_valid, s4_valid, s5_valid;

  logic [CW-1:0] s0_row, s0_col;
  logic [VW-1:0] s0_value;
  logic          s0_drop;

  logic [2*CW-1:0] s1_prod_r, s1_prod_c;
  logic [VW-1:0]   s1_value;
  logic            s1_drop;

  logic            rdiv_valid, cdiv_valid;
  logic [VW-1:0]   rdiv_value;
  logic            cdiv_drop;
  logic [2*CW-1:0] rdiv_quo, cdiv_quo;
  logic [CW-1:0]   rdiv_rem, cdiv_rem;

  logic [CW-1:0]     s3_r0, s3_c0;
  logic [SIDE_W-1:0] s3_nr, s3_nc;
  logic [VW-1:0]     s3_value;
  logic              s3_drop;

  blk_t              s4_blk;
  logic [CELL_W-1:0] s4_cells;
  logic [VW-1:0]     s4_mag;

  logic              sdiv_valid;
  blk_t              sdiv_blk;
  logic [VW-1:0]     sdiv_quo;
  logic [CELL_W-1:0] sdiv_rem;

  blk_t          s5_blk;
  logic [VW-1:0] s5_share;

  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
      s3_valid <= rdiv_valid & cdiv_valid;
      s4_valid <= s3_valid;
      s5_valid <= sdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_row   <= in_item.in_row;
      s0_col   <= in_item.in_col;
      s0_value <= in_item.in_value;
      s0_drop  <= (in_item.in_value == '0) || (source_rows == '0) || (source_cols == '0) ||
                  (target_rows == '0) || (target_cols == '0) ||
                  (in_item.in_row >= source_rows) || (in_item.in_col >= source_cols);

      s1_prod_r <= s0_row * target_rows;
      s1_prod_c <= s0_col * target_cols;
      s1_value  <= s0_value;
      s1_drop   <= s0_drop;

      s3_r0    <= rdiv_quo[CW-1:0];
      s3_c0    <= cdiv_quo[CW-1:0];
      s3_nr    <= block_side(rdiv_rem, target_rows, source_rows);
      s3_nc    <= block_side(cdiv_rem, target_cols, source_cols);
      s3_value <= rdiv_value;
      s3_drop  <= cdiv_drop;

      s4_blk.drop <= s3_drop;
      s4_blk.neg  <= s3_value[VW-1];
      s4_blk.r0   <= s3_r0;
      s4_blk.c0   <= s3_c0;
      s4_blk.nr   <= s3_nr;
      s4_blk.nc   <= s3_nc;
      s4_cells    <= CELL_W'(s3_nr) * CELL_W'(s3_nc);
      s4_mag      <= s3_value[VW-1] ? (~s3_value + VW'(1)) : s3_value;

      s5_blk   <= sdiv_blk;
      s5_share <= sdiv_blk.neg ? (~sdiv_quo + VW'(1)) : sdiv_quo;
    end
  end

  sne_divpipe #(
    .DIVIDEND_W (2 * CW),
    .DIVISOR_W  (CW),
    .STEPS      (sne_pkg::INDEX_DIV_STEPS),
    .TAG_W      (VW)
  ) u_row_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .in_tag    (s1_value),
    .dividend  (s1_prod_r),
    .divisor   (source_rows),
    .out_valid (rdiv_valid),
    .out_tag   (rdiv_value),
    .quotient  (rdiv_quo),
    .remainder (rdiv_rem)
  );

  sne_divpipe #(
    .DIVIDEND_W (2 * CW),
    .DIVISOR_W  (CW),
    .STEPS      (sne_pkg::INDEX_DIV_STEPS),
    .TAG_W      (1)
  ) u_col_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .in_tag    (s1_drop),
    .dividend  (s1_prod_c),
    .divisor   (source_cols),
    .out_valid (cdiv_valid),
    .out_tag   (cdiv_drop),
    .quotient  (cdiv_quo),
    .remainder (cdiv_rem)
  );

  sne_divpipe #(
    .DIVIDEND_W (VW),
    .DIVISOR_W  (CELL_W),
    .STEPS      (sne_pkg::SHARE_DIV_STEPS),
    .TAG_W      ($bits(blk_t))
  ) u_share_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s4_valid),
    .in_tag    (s4_blk),
    .dividend  (s4_mag),
    .divisor   (s4_cells),
    .out_valid (sdiv_valid),
    .out_tag   (sdiv_blk),
    .quotient  (sdiv_quo),
    .remainder (sdiv_rem)
  );

  // cell emitter
  logic              em_valid;
  logic [CW-1:0]     em_r0, em_c0;
  logic [SIDE_W-1:0] em_nr, em_nc, em_dr, em_dc;
  logic [VW-1:0]     em_share;
  logic              em_last_col, em_last;
  logic              out_adv, emit;

  assign out_adv     = !out_valid || !out_stall;
  assign emit        = em_valid && out_adv;
  assign em_last_col = (em_dc == SIDE_W'(em_nc - SIDE_W'(1)));
  assign em_last     = em_last_col && (em_dr == SIDE_W'(em_nr - SIDE_W'(1)));
  assign em_load     = s5_valid && (!em_valid || (emit && em_last));
  assign adv         = !s5_valid || em_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= em_valid;
      end
      if (em_load) begin
        em_valid <= !s5_blk.drop;
      end else if (emit && em_last) begin
        em_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.out_row   <= em_r0 + CW'(em_dr);
      out_item.out_col   <= em_c0 + CW'(em_dc);
      out_item.out_value <= em_share;
      out_item.out_last  <= em_last;
      if (!em_last) begin
        if (em_last_col) begin
          em_dc <= '0;
          em_dr <= em_dr + SIDE_W'(1);
        end else begin
          em_dc <= em_dc + SIDE_W'(1);
        end
      end
    end
    if (em_load) begin
      em_r0    <= s5_blk.r0;
      em_c0    <= s5_blk.c0;
      em_nr    <= s5_blk.nr;
      em_nc    <= s5_blk.nc;
      em_share <= s5_share;
      em_dr    <= '0;
      em_dc    <= '0;
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    rdiv_valid == cdiv_valid)
    else $error("row and column dividers out of step");

  a_load_on_last: assert property (@(posedge clk) disable iff (rst)
    em_load && em_valid |-> emit && em_last)
    else $error("emitter reloaded before its last cell left");

  a_cell_in_block: assert property (@(posedge clk) disable iff (rst)
    em_valid |-> (em_dr < em_nr) && (em_dc < em_nc))
    else $error("emitter cell outside its block");

  a_share_rem: assert property (@(posedge clk) disable iff (rst)
    sdiv_valid && !sdiv_blk.drop |->
      sdiv_rem < CELL_W'(CELL_W'(sdiv_blk.nr) * CELL_W'(sdiv_blk.nc)))
    else $error("share remainder not below cell count");

  a_hold_tail: assert property (@(posedge clk) disable iff (rst)
    s5_valid && !em_load |=> s5_valid && $stable(s5_share))
    else $error("pipeline tail item changed while held");

endmodule
